// File: src/instruction_parameter_decoder_top_macros.svh
// Assertion macros shared by the parameter decoder RTL.
`ifndef INSTRUCTION_PARAMETER_DECODER_TOP_MACROS_SVH
`define INSTRUCTION_PARAMETER_DECODER_TOP_MACROS_SVH

`ifndef ASSERT_OFF
// Check that a property holds on every clock edge outside reset.
`define IPD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Check that a condition never holds on a clock edge outside reset.
`define IPD_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`else
`define IPD_ASSERT(lbl, prop, msg)
`define IPD_ASSERT_NEVER(lbl, cond, msg)
`endif

`endif

// File: src/ipd_pkg.sv
// Types, constants and helper functions of the instruction parameter decoder.
package ipd_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned ValueW  = 32;
  localparam int unsigned LenW    = 5;
  localparam int unsigned MaskW   = 16;
  localparam int unsigned BlW     = 3;
  localparam int unsigned CountW  = 3;

  localparam logic [ByteW-1:0] OpcodeMax      = 8'd16;
  localparam logic [MaskW-1:0] HasCodingReset = 16'd46846;
  localparam logic [MaskW-1:0] ShortDirReset  = 16'd28416;
  // Kinds of an opcode without a coding byte: direct, none, none, none
  localparam logic [ByteW-1:0] DefaultKinds   = 8'h80;

  // Parameter kinds
  localparam logic [1:0] KindNone = 2'd0;
  localparam logic [1:0] KindReg  = 2'd1;
  localparam logic [1:0] KindDir  = 2'd2;
  localparam logic [1:0] KindInd  = 2'd3;

  localparam logic [1:0] LastIndex = 2'd3;

  typedef enum logic [1:0] {
    REG_HAS_CODING   = 2'd0,
    REG_SHORT_DIRECT = 2'd1
  } cfg_reg_e;

  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_CODING = 2'd1,
    PH_PARAMS = 2'd2
  } phase_e;

  typedef struct packed {
    logic             start_req;
    logic [ByteW-1:0] data_byte;
  } in_word_t;

  typedef struct packed {
    logic [1:0]        param_index;
    logic [1:0]        param_kind;
    logic [ValueW-1:0] param_value;
    logic [LenW-1:0]   instr_length;
    logic              last;
    logic              bad_opcode;
  } out_word_t;

  // One byte's worth of results: the first one in full, the rest are
  // zero-length parameters that follow it with the same length.
  typedef struct packed {
    logic [CountW-1:0] count;
    logic [1:0]        index;
    logic [1:0]        kind;
    logic [ValueW-1:0] value;
    logic [LenW-1:0]   length;
    logic              bad;
  } step_rec_t;

  // Pick the kind of parameter idx, most significant pair first.
  function automatic logic [1:0] kind_of(logic [ByteW-1:0] kinds, logic [1:0] idx);
    logic [1:0] k;
    case (idx)
      2'd0:    k = kinds[7:6];
      2'd1:    k = kinds[5:4];
      2'd2:    k = kinds[3:2];
      default: k = kinds[1:0];
    endcase
    return k;
  endfunction

  // Byte count of a parameter kind.
  function automatic logic [BlW-1:0] bytes_of(logic [1:0] kind, logic short_dir);
    logic [BlW-1:0] n;
    case (kind)
      KindReg: n = 3'd1;
      KindDir: n = short_dir ? 3'd2 : 3'd4;
      KindInd: n = 3'd2;
      default: n = 3'd0;
    endcase
    return n;
  endfunction

endpackage

// File: src/ipd_front.sv
// Front end: takes instruction bytes, tracks decode state, emits step records.
module ipd_front (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  ipd_pkg::in_word_t       in_word_i,
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  logic [1:0]              cfg_index_i,
  input  logic [ipd_pkg::MaskW-1:0] cfg_data_i,
  input  logic                    q_full_i,
  output logic                    push_o,
  output ipd_pkg::step_rec_t      rec_o
);
  import ipd_pkg::*;

  phase_e            phase_q, phase_d;
  logic [4:0]        opcode_q, opcode_d;
  logic [ByteW-1:0]  kinds_q, kinds_d;
  logic [1:0]        cnt_q, cnt_d;
  logic [BlW-1:0]    bl_q, bl_d;
  logic [ValueW-1:0] acc_q, acc_d;
  logic [LenW-1:0]   len_q, len_d;
  logic [MaskW-1:0]  hcb_q, hcb_d;
  logic [MaskW-1:0]  sdm_q, sdm_d;

  logic              accept;
  logic              bad_op;
  logic [3:0]        new_bit;
  logic [3:0]        cur_bit;

  // Drain inputs and outputs
  logic              do_drain;
  logic [ByteW-1:0]  dr_kinds;
  logic [1:0]        dr_cnt;
  logic [BlW-1:0]    dr_bl;
  logic [ValueW-1:0] dr_acc;
  logic [LenW-1:0]   dr_len;
  logic              dr_short;
  logic [CountW-1:0] dr_n;
  logic [1:0]        dr_cnt_f;
  logic [BlW-1:0]    dr_bl_f;
  logic              dr_busy_f;

  assign in_stall_o  = q_full_i;
  assign cfg_ready_o = 1'b1;
  assign accept      = in_valid_i && !in_stall_o;
  assign bad_op      = (in_word_i.data_byte == '0) || (in_word_i.data_byte > OpcodeMax);
  assign new_bit     = in_word_i.data_byte[3:0] - 4'd1;
  assign cur_bit     = opcode_q[3:0] - 4'd1;

  // Pick where the parameter walk starts for the accepted byte
  always_comb begin
    do_drain = 1'b0;
    dr_kinds = kinds_q;
    dr_cnt   = 2'd0;
    dr_bl    = '0;
    dr_acc   = '0;
    dr_len   = len_q;
    dr_short = sdm_q[cur_bit];

    if (accept) begin
      if (in_word_i.start_req) begin
        if (!bad_op && !hcb_q[new_bit]) begin
          do_drain = 1'b1;
          dr_kinds = DefaultKinds;
          dr_short = sdm_q[new_bit];
          dr_bl    = bytes_of(kind_of(DefaultKinds, 2'd0), sdm_q[new_bit]);
          dr_len   = 5'd1;
        end
      end else if (phase_q == PH_CODING) begin
        do_drain = 1'b1;
        dr_kinds = in_word_i.data_byte;
        dr_bl    = bytes_of(kind_of(in_word_i.data_byte, 2'd0), sdm_q[cur_bit]);
        dr_len   = len_q + 5'd1;
      end else if (phase_q == PH_PARAMS) begin
        do_drain = 1'b1;
        dr_cnt   = cnt_q;
        dr_acc   = {acc_q[ValueW-ByteW-1:0], in_word_i.data_byte};
        dr_bl    = (bl_q != '0) ? bl_q - 3'd1 : bl_q;
        dr_len   = len_q + 5'd1;
      end
    end
  end

  // Walk up to four parameters that complete in this step
  always_comb begin
    logic [1:0]     c;
    logic [BlW-1:0] b;
    logic           busy;
    logic [CountW-1:0] n;
    c    = dr_cnt;
    b    = dr_bl;
    busy = 1'b1;
    n    = '0;
    for (int j = 0; j < 4; j++) begin
      if (busy && (b == '0)) begin
        n = n + 3'd1;
        if (c == LastIndex) begin
          busy = 1'b0;
        end else begin
          c = c + 2'd1;
          b = bytes_of(kind_of(dr_kinds, c), dr_short);
        end
      end
    end
    dr_n      = n;
    dr_cnt_f  = c;
    dr_bl_f   = b;
    dr_busy_f = busy;
  end

  // Decode the accepted byte
  always_comb begin
    phase_d  = phase_q;
    opcode_d = opcode_q;
    kinds_d  = kinds_q;
    cnt_d    = cnt_q;
    bl_d     = bl_q;
    acc_d    = acc_q;
    len_d    = len_q;
    rec_o    = '0;
    push_o   = 1'b0;

    if (accept) begin
      if (in_word_i.start_req) begin
        len_d = 5'd1;
        if (bad_op) begin
          phase_d      = PH_IDLE;
          opcode_d     = '0;
          rec_o.count  = 3'd1;
          rec_o.index  = 2'd0;
          rec_o.kind   = KindNone;
          rec_o.value  = '0;
          rec_o.length = 5'd1;
          rec_o.bad    = 1'b1;
          push_o       = 1'b1;
        end else begin
          opcode_d = in_word_i.data_byte[4:0];
          if (hcb_q[new_bit]) begin
            phase_d = PH_CODING;
          end else begin
            kinds_d = DefaultKinds;
          end
        end
      end else if (phase_q == PH_CODING) begin
        kinds_d = in_word_i.data_byte;
        len_d   = len_q + 5'd1;
      end else if (phase_q == PH_PARAMS) begin
        len_d = len_q + 5'd1;
      end
    end

    // Advance to the next waiting parameter and hand finished ones on
    if (do_drain) begin
      phase_d      = dr_busy_f ? PH_PARAMS : PH_IDLE;
      cnt_d        = dr_cnt_f;
      bl_d         = dr_bl_f;
      acc_d        = (dr_n != '0) ? '0 : dr_acc;
      rec_o.count  = dr_n;
      rec_o.index  = dr_cnt;
      rec_o.kind   = kind_of(dr_kinds, dr_cnt);
      rec_o.value  = dr_acc;
      rec_o.length = dr_len;
      rec_o.bad    = 1'b0;
      push_o       = (dr_n != '0);
    end
  end

  // Take configuration writes
  always_comb begin
    hcb_d = hcb_q;
    sdm_d = sdm_q;
    if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_HAS_CODING:   hcb_d = cfg_data_i;
        REG_SHORT_DIRECT: sdm_d = cfg_data_i;
        default: ;
      endcase
    end
  end

  // Hold decode state and registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_IDLE;
      opcode_q <= '0;
      kinds_q  <= '0;
      cnt_q    <= '0;
      bl_q     <= '0;
      acc_q    <= '0;
      len_q    <= '0;
      hcb_q    <= HasCodingReset;
      sdm_q    <= ShortDirReset;
    end else begin
      phase_q  <= phase_d;
      opcode_q <= opcode_d;
      kinds_q  <= kinds_d;
      cnt_q    <= cnt_d;
      bl_q     <= bl_d;
      acc_q    <= acc_d;
      len_q    <= len_d;
      hcb_q    <= hcb_d;
      sdm_q    <= sdm_d;
    end
  end

endmodule

// File: src/ipd_queue.sv
// Two-entry queue of step records between front and back end.
module ipd_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  ipd_pkg::step_rec_t rec_i,
  input  logic               pop_i,
  output ipd_pkg::step_rec_t head_o,
  output logic               full_o,
  output logic               empty_o
);
  import ipd_pkg::*;

  step_rec_t  mem_q [2];
  logic       wptr_q, rptr_q;
  logic [1:0] cnt_q, cnt_d;
  logic       do_push, do_pop;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign head_o  = mem_q[rptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  // Track fill level
  always_comb begin
    cnt_d = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  // Advance pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (do_push) begin
        wptr_q <= !wptr_q;
      end
      if (do_pop) begin
        rptr_q <= !rptr_q;
      end
    end
  end

  // Store pushed records
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= rec_i;
    end
  end

endmodule

// File: src/ipd_back.sv
// Back end: expands each step record into one result word per parameter.
module ipd_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ipd_pkg::step_rec_t head_i,
  input  logic               empty_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output ipd_pkg::out_word_t out_word_o
);
  import ipd_pkg::*;

  logic [1:0] sub_q, sub_d;
  logic       out_accept;
  logic       at_end;
  logic [1:0] idx;

  assign out_valid_o = !empty_i;
  assign out_accept  = out_valid_o && !out_stall_i;
  assign at_end      = ({1'b0, sub_q} == head_i.count - 3'd1);
  assign pop_o       = out_accept && at_end;
  assign idx         = head_i.index + sub_q;

  // Build the current result word; later ones in a record are empty parameters
  always_comb begin
    out_word_o.param_index  = idx;
    out_word_o.param_kind   = (sub_q == 2'd0) ? head_i.kind : KindNone;
    out_word_o.param_value  = (sub_q == 2'd0) ? head_i.value : '0;
    out_word_o.instr_length = head_i.length;
    out_word_o.last         = head_i.bad || (idx == LastIndex);
    out_word_o.bad_opcode   = head_i.bad;
  end

  // Step through the record, restart on pop
  always_comb begin
    sub_d = sub_q;
    if (pop_o) begin
      sub_d = 2'd0;
    end else if (out_accept) begin
      sub_d = sub_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sub_q <= '0;
    end else begin
      sub_q <= sub_d;
    end
  end

endmodule

// File: src/instruction_parameter_decoder_top.sv
// Top level of the instruction parameter decoder: front end, record queue, back end.
// Usage: one instruction byte is accepted every cycle while the record queue has
// room. A byte that completes k parameters (k from 0 to 4, or one error word for a
// bad opcode) yields k result words from the back end, one per cycle while the output
// is not stalled; its record is pushed into the queue when the byte is accepted. The
// input stalls only when the two-entry record queue between front and back end is
// full, which depends on the one-word-per-cycle output and the output stall.
`include "instruction_parameter_decoder_top_macros.svh"
module instruction_parameter_decoder_top (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  ipd_pkg::in_word_t         in_word_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output ipd_pkg::out_word_t        out_word_o,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [1:0]                cfg_index_i,
  input  logic [ipd_pkg::MaskW-1:0] cfg_data_i
);
  import ipd_pkg::*;

  step_rec_t rec, head;
  logic      push, pop, q_full, q_empty;

  ipd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_word_i   (in_word_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .q_full_i    (q_full),
    .push_o      (push),
    .rec_o       (rec)
  );

  ipd_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .rec_i   (rec),
    .pop_i   (pop),
    .head_o  (head),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  ipd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .empty_i     (q_empty),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o)
  );

  // Checks
  `IPD_ASSERT_NEVER(a_no_overflow, push && q_full, "record pushed into full queue")
  `IPD_ASSERT(a_bad_is_last, out_valid_o && out_word_o.bad_opcode |-> out_word_o.last && out_word_o.param_index == 2'd0, "error word not last or not index zero")
  `IPD_ASSERT(a_bad_gives_word, in_valid_i && !in_stall_o && in_word_i.start_req && (in_word_i.data_byte == 8'd0 || in_word_i.data_byte > OpcodeMax) |=> out_valid_o, "bad opcode gave no result")

endmodule
